// ===== src/pma_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the modular ALU.
package pma_pkg;

	localparam logic [29:0] MODULUS    = 30'd998244353;
	localparam logic [29:0] FERMAT_EXP = MODULUS - 30'd2;

	localparam logic [63:0] MU_FULL    = (64'd1 << 60) / 64'd998244353;
	localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

	localparam logic [30:0] TWO30_FULL = (31'd1 << 30) - {1'b0, MODULUS};
	localparam logic [29:0] TWO30_MOD  = TWO30_FULL[29:0];

	localparam logic [31:0] MOD_X1 = {2'b00, MODULUS};
	localparam logic [31:0] MOD_X2 = {1'b0, MODULUS, 1'b0};

	typedef enum logic [2:0] {
		OP_REDUCE = 3'd0,
		OP_ADD    = 3'd1,
		OP_SUB    = 3'd2,
		OP_MUL    = 3'd3,
		OP_DIV    = 3'd4,
		OP_NEG    = 3'd5,
		OP_POW    = 3'd6,
		OP_INV    = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		SEL_A_B,
		SEL_ACC_BASE,
		SEL_BASE_BASE,
		SEL_RED_HI,
		SEL_RED_LO,
		SEL_A_ACC
	} mul_sel_t;

	typedef enum logic {
		DEST_ACC,
		DEST_BASE
	} dest_t;

	typedef struct packed {
		logic     load;
		logic     init_pow;
		logic     issue;
		mul_sel_t sel;
		dest_t    dest;
		logic     exp_shift;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic exp_zero;
		logic exp_lsb;
		logic pow_trivial;
		op_t  op;
	} sts_t;

endpackage

// ===== src/pma_ctrl.sv =====
// Controller state machine that sequences the modular multiply pipeline for each word.
module pma_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  pma_pkg::sts_t sts,
	output pma_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RED_LO,
		ST_LOOP,
		ST_SQUARE,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t ret_q;
	state_t state_d;
	state_t ret_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.sel       = pma_pkg::SEL_A_B;
		cmd.dest      = pma_pkg::DEST_ACC;
		state_d       = state_q;
		ret_d         = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.op)
					pma_pkg::OP_REDUCE: begin
						cmd.issue = 1'b1;
						cmd.sel   = pma_pkg::SEL_RED_HI;
						ret_d     = ST_RED_LO;
						state_d   = ST_WAIT;
					end
					pma_pkg::OP_MUL: begin
						cmd.issue = 1'b1;
						cmd.sel   = pma_pkg::SEL_A_B;
						ret_d     = ST_FINISH;
						state_d   = ST_WAIT;
					end
					pma_pkg::OP_DIV, pma_pkg::OP_INV: begin
						cmd.init_pow = 1'b1;
						state_d      = ST_LOOP;
					end
					pma_pkg::OP_POW: begin
						cmd.init_pow = 1'b1;
						state_d      = sts.pow_trivial ? ST_FINISH : ST_LOOP;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_RED_LO: begin
				cmd.issue = 1'b1;
				cmd.sel   = pma_pkg::SEL_RED_LO;
				ret_d     = ST_FINISH;
				state_d   = ST_WAIT;
			end
			ST_LOOP: begin
				if (sts.exp_zero) begin
					if (sts.op == pma_pkg::OP_DIV) begin
						cmd.issue = 1'b1;
						cmd.sel   = pma_pkg::SEL_A_ACC;
						ret_d     = ST_FINISH;
						state_d   = ST_WAIT;
					end else begin
						state_d = ST_FINISH;
					end
				end else begin
					if (sts.exp_lsb) begin
						cmd.issue = 1'b1;
						cmd.sel   = pma_pkg::SEL_ACC_BASE;
					end
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.issue     = 1'b1;
				cmd.sel       = pma_pkg::SEL_BASE_BASE;
				cmd.dest      = pma_pkg::DEST_BASE;
				cmd.exp_shift = 1'b1;
				ret_d         = ST_LOOP;
				state_d       = ST_WAIT;
			end
			ST_WAIT: begin
				if (!sts.busy) begin
					state_d = ret_q;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/pma_dp.sv =====
// Datapath with operand registers, exponent shifter and a three-stage Barrett multiply pipeline.
module pma_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  pma_pkg::cmd_t cmd,
	output pma_pkg::sts_t sts,
	input  logic [2:0]    opcode,
	input  logic [29:0]   operand_a,
	input  logic [29:0]   operand_b,
	input  logic [63:0]   wide_operand,
	output logic [29:0]   residue,
	output logic          operands_equal
);

	pma_pkg::op_t     op_q;
	logic [29:0]      a_q;
	logic [29:0]      b_q;
	logic             neg_q;
	logic             ptriv_q;
	logic [63:0]      mag_q;
	logic [62:0]      exp_q;
	logic [29:0]      acc_q;
	logic [29:0]      base_q;
	logic [29:0]      res_q;
	logic             eq_q;

	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	pma_pkg::dest_t   dest_s1;
	pma_pkg::dest_t   dest_s2;
	pma_pkg::dest_t   dest_s3;
	logic [59:0]      x_s1;
	logic [29:0]      q_s2;
	logic [31:0]      xlo_s2;
	logic [31:0]      r_s3;

	logic [29:0]      fold_a;
	logic [29:0]      fold_b;
	logic [63:0]      mag_in;
	logic [29:0]      mul_a;
	logic [29:0]      mul_b;
	logic [29:0]      mul_c;
	logic [59:0]      prod;
	logic [61:0]      qprod;
	logic [59:0]      qp;
	logic [31:0]      r_m1;
	logic [31:0]      r_m2;
	logic [29:0]      wb;
	logic [30:0]      sum;
	logic [29:0]      red_res;
	logic [29:0]      res_d;

	assign fold_a = (operand_a >= pma_pkg::MODULUS) ? operand_a - pma_pkg::MODULUS : operand_a;
	assign fold_b = (operand_b >= pma_pkg::MODULUS) ? operand_b - pma_pkg::MODULUS : operand_b;
	assign mag_in = wide_operand[63] ? (64'd0 - wide_operand) : wide_operand;

	always_comb begin
		mul_a = a_q;
		mul_b = b_q;
		mul_c = '0;
		case (cmd.sel)
			pma_pkg::SEL_A_B: begin
				mul_a = a_q;
				mul_b = b_q;
			end
			pma_pkg::SEL_ACC_BASE: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			pma_pkg::SEL_BASE_BASE: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			pma_pkg::SEL_RED_HI: begin
				mul_a = {26'd0, mag_q[63:60]};
				mul_b = pma_pkg::TWO30_MOD;
				mul_c = mag_q[59:30];
			end
			pma_pkg::SEL_RED_LO: begin
				mul_a = acc_q;
				mul_b = pma_pkg::TWO30_MOD;
				mul_c = mag_q[29:0];
			end
			pma_pkg::SEL_A_ACC: begin
				mul_a = a_q;
				mul_b = acc_q;
			end
			default: begin
				mul_a = a_q;
				mul_b = b_q;
			end
		endcase
	end

	assign prod  = {30'd0, mul_a} * {30'd0, mul_b};
	assign qprod = {31'd0, x_s1[59:29]} * {31'd0, pma_pkg::BARRETT_MU};
	assign qp    = {30'd0, q_s2} * {30'd0, pma_pkg::MODULUS};

	// The Barrett estimate falls short of the true quotient by at most two.
	assign r_m1 = r_s3 - pma_pkg::MOD_X1;
	assign r_m2 = r_s3 - pma_pkg::MOD_X2;
	assign wb   = (r_s3 >= pma_pkg::MOD_X2) ? r_m2[29:0] :
	              (r_s3 >= pma_pkg::MOD_X1) ? r_m1[29:0] : r_s3[29:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dest_s1 <= cmd.dest;
		x_s1    <= prod + {30'd0, mul_c};
		dest_s2 <= dest_s1;
		q_s2    <= qprod[60:31];
		xlo_s2  <= x_s1[31:0];
		dest_s3 <= dest_s2;
		r_s3    <= xlo_s2 - qp[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= pma_pkg::op_t'(opcode);
			a_q     <= fold_a;
			b_q     <= fold_b;
			neg_q   <= wide_operand[63];
			ptriv_q <= wide_operand[63] || (wide_operand == 64'd0);
			mag_q   <= mag_in;
		end
		if (cmd.init_pow) begin
			acc_q  <= 30'd1;
			base_q <= (op_q == pma_pkg::OP_DIV) ? b_q : a_q;
			exp_q  <= (op_q == pma_pkg::OP_POW) ? mag_q[62:0] : {33'd0, pma_pkg::FERMAT_EXP};
		end else begin
			if (v_s3 && dest_s3 == pma_pkg::DEST_ACC) begin
				acc_q <= wb;
			end
			if (v_s3 && dest_s3 == pma_pkg::DEST_BASE) begin
				base_q <= wb;
			end
			if (cmd.exp_shift) begin
				exp_q <= exp_q >> 1;
			end
		end
		if (cmd.finish) begin
			res_q <= res_d;
			eq_q  <= (a_q == b_q);
		end
	end

	assign sum     = {1'b0, a_q} + {1'b0, b_q};
	assign red_res = (neg_q && acc_q != 30'd0) ? pma_pkg::MODULUS - acc_q : acc_q;

	always_comb begin
		case (op_q)
			pma_pkg::OP_REDUCE: res_d = red_res;
			pma_pkg::OP_ADD: begin
				res_d = (sum >= {1'b0, pma_pkg::MODULUS}) ?
				        30'(sum - {1'b0, pma_pkg::MODULUS}) : sum[29:0];
			end
			pma_pkg::OP_SUB: begin
				res_d = (a_q >= b_q) ? a_q - b_q : a_q + (pma_pkg::MODULUS - b_q);
			end
			pma_pkg::OP_NEG: res_d = (a_q != 30'd0) ? pma_pkg::MODULUS - a_q : 30'd0;
			default:         res_d = acc_q;
		endcase
	end

	assign sts.busy        = v_s1 | v_s2 | v_s3;
	assign sts.exp_zero    = (exp_q == 63'd0);
	assign sts.exp_lsb     = exp_q[0];
	assign sts.pow_trivial = ptriv_q;
	assign sts.op          = op_q;

	assign residue        = res_q;
	assign operands_equal = eq_q;

endmodule

// ===== src/prime_modular_alu_core.sv =====
// Top level of the modular arithmetic unit over the prime 998244353.
//
// Channel  Direction  Handshake           Word
// in       sink       in_valid/in_stall   opcode, operand_a, operand_b, wide_operand
// out      source     out_valid/out_stall residue, operands_equal
//
// One word is worked on at a time. Inverse, div and pow take one round per exponent bit,
// each round waiting for the shared three-stage multiply pipeline.
// Reset clears the controller and the pipeline valid bits; no clearing pass is needed.
// A finished result waits in the output register while the next word is accepted.
module prime_modular_alu_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [29:0] operand_a,
	input  logic [29:0] operand_b,
	input  logic [63:0] wide_operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [29:0] residue,
	output logic        operands_equal
);

	pma_pkg::cmd_t cmd;
	pma_pkg::sts_t sts;

	pma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pma_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.wide_operand   (wide_operand),
		.residue        (residue),
		.operands_equal (operands_equal)
	);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the modular arithmetic unit over the prime 998244353.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] MOD64       = {34'd0, pma_pkg::MODULUS};
	localparam logic [29:0] TOP30       = 30'h3FFF_FFFF;
	localparam int          RANDOM_WORDS = 1400;
	localparam int          DRAIN_AT    = 800;
	localparam int          LONG_HOLD   = 600;
	localparam int          TAIL_CYCLES = 400;
	localparam int          CYCLE_LIMIT = 3_000_000;

	typedef struct {
		pma_pkg::op_t op;
		logic [29:0]  a;
		logic [29:0]  b;
		logic [63:0]  w;
		bit           typed;
		logic [29:0]  residue;
		bit           equal;
	} alu_request_t;

	typedef struct {
		logic [29:0] residue;
		bit          equal;
	} alu_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic [29:0] operand_a;
	logic [29:0] operand_b;
	logic [63:0] wide_operand;
	logic        out_valid;
	logic        out_stall;
	logic [29:0] residue;
	logic        operands_equal;

	bit          row_typed;
	logic [29:0] row_residue;
	bit          row_equal;

	alu_request_t directed_requests[$];
	alu_result_t  awaited_results[$];
	int           fault_count = 0;
	int           words_checked = 0;
	int           cycle_count = 0;

	prime_modular_alu_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.wide_operand   (wide_operand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.residue        (residue),
		.operands_equal (operands_equal)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [29:0] fold_operand(logic [29:0] x);
		return (x >= pma_pkg::MODULUS) ? x - pma_pkg::MODULUS : x;
	endfunction

	function automatic logic [29:0] mulmod(logic [29:0] x, logic [29:0] y);
		logic [63:0] prod;
		prod = {34'd0, x} * {34'd0, y};
		return 30'(prod % MOD64);
	endfunction

	function automatic logic [29:0] powmod(logic [29:0] base, logic [63:0] ex);
		logic [29:0] acc;
		acc = 30'd1;
		while (ex != 64'd0) begin
			if (ex[0])
				acc = mulmod(acc, base);
			base = mulmod(base, base);
			ex = ex >> 1;
		end
		return acc;
	endfunction

	function automatic logic [29:0] reduce_wide(logic [63:0] raw);
		logic [63:0] mag;
		if (raw[63]) begin
			mag = (64'd0 - raw) % MOD64;
			return (mag == 64'd0) ? 30'd0 : pma_pkg::MODULUS - mag[29:0];
		end
		return 30'(raw % MOD64);
	endfunction

	function automatic alu_result_t predict_word(alu_request_t req);
		alu_result_t r;
		logic [29:0] a;
		logic [29:0] b;
		logic [30:0] sum;
		a = fold_operand(req.a);
		b = fold_operand(req.b);
		r.equal = (a == b);
		case (req.op)
			pma_pkg::OP_REDUCE: r.residue = reduce_wide(req.w);
			pma_pkg::OP_ADD: begin
				sum = {1'b0, a} + {1'b0, b};
				r.residue = (sum >= {1'b0, pma_pkg::MODULUS}) ?
				            30'(sum - {1'b0, pma_pkg::MODULUS}) : sum[29:0];
			end
			pma_pkg::OP_SUB: r.residue = (a >= b) ? a - b : a + (pma_pkg::MODULUS - b);
			pma_pkg::OP_MUL: r.residue = mulmod(a, b);
			pma_pkg::OP_DIV: r.residue = mulmod(a, powmod(b, {34'd0, pma_pkg::FERMAT_EXP}));
			pma_pkg::OP_NEG: r.residue = (a == 30'd0) ? 30'd0 : pma_pkg::MODULUS - a;
			pma_pkg::OP_POW: begin
				r.residue = (req.w[63] || req.w == 64'd0) ? 30'd1 : powmod(a, req.w);
			end
			default: r.residue = powmod(a, {34'd0, pma_pkg::FERMAT_EXP});
		endcase
		return r;
	endfunction

	function automatic int idle_cycles();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55)
			return 0;
		if (k < 85)
			return $urandom_range(1, 3);
		if (k < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [29:0] random_operand();
		case ($urandom_range(0, 19))
			0: return 30'd0;
			1: return pma_pkg::MODULUS - 30'd1;
			2: return pma_pkg::MODULUS;
			3: return TOP30;
			4, 5: return 30'($urandom);
			default: return 30'($urandom_range(0, pma_pkg::MODULUS - 30'd1));
		endcase
	endfunction

	function automatic alu_request_t random_request();
		alu_request_t req;
		req.op = pma_pkg::op_t'($urandom_range(0, 7));
		req.a = random_operand();
		req.b = ($urandom_range(0, 9) == 0) ? req.a : random_operand();
		req.w = {$urandom, $urandom};
		if (req.op == pma_pkg::OP_POW) begin
			case ($urandom_range(0, 5))
				0, 1: req.w = 64'($urandom_range(0, 64));
				2: req.w[63] = 1'b0;
				3: req.w[63] = 1'b1;
				default: ;
			endcase
		end else if (req.op == pma_pkg::OP_REDUCE && $urandom_range(0, 3) == 0) begin
			req.w = {{34{req.w[63]}}, req.w[29:0]};
		end
		req.typed = 1'b0;
		req.residue = '0;
		req.equal = 1'b0;
		return req;
	endfunction

	task automatic add_row(input pma_pkg::op_t op, input logic [29:0] a, input logic [29:0] b,
			input logic [63:0] w, input bit typed, input logic [29:0] res, input bit eq);
		alu_request_t req;
		req.op = op;
		req.a = a;
		req.b = b;
		req.w = w;
		req.typed = typed;
		req.residue = res;
		req.equal = eq;
		directed_requests.push_back(req);
	endtask

	task automatic send_word(input alu_request_t req, input bit calm);
		int idle;
		idle = calm ? 0 : idle_cycles();
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= req.op;
		operand_a <= req.a;
		operand_b <= req.b;
		wide_operand <= req.w;
		row_typed <= req.typed;
		row_residue <= req.residue;
		row_equal <= req.equal;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	task automatic note_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", what);
	endtask

	initial begin : sender
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= pma_pkg::OP_REDUCE;
		operand_a <= '0;
		operand_b <= '0;
		wide_operand <= '0;
		row_typed <= 1'b0;
		row_residue <= '0;
		row_equal <= 1'b0;

		add_row(pma_pkg::OP_REDUCE, 30'd0, 30'd0, 64'd0, 1'b1, 30'd0, 1'b1);
		add_row(pma_pkg::OP_REDUCE, 30'd1, 30'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			pma_pkg::MODULUS - 30'd1, 1'b0);
		add_row(pma_pkg::OP_REDUCE, pma_pkg::MODULUS, 30'd0, MOD64, 1'b1, 30'd0, 1'b1);
		add_row(pma_pkg::OP_REDUCE, 30'd5, 30'd5, -MOD64, 1'b1, 30'd0, 1'b1);
		add_row(pma_pkg::OP_REDUCE, TOP30, 30'd9, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0, 1'b0);
		add_row(pma_pkg::OP_REDUCE, 30'd9, TOP30, 64'h8000_0000_0000_0000, 1'b0, '0, 1'b0);
		add_row(pma_pkg::OP_ADD, pma_pkg::MODULUS - 30'd1, 30'd1, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1, 30'd0, 1'b0);
		add_row(pma_pkg::OP_ADD, TOP30, 30'd0, 64'd0, 1'b1, 30'd75497470, 1'b0);
		add_row(pma_pkg::OP_SUB, 30'd0, 30'd1, 64'h8000_0000_0000_0000, 1'b1,
			pma_pkg::MODULUS - 30'd1, 1'b0);
		add_row(pma_pkg::OP_SUB, TOP30, TOP30, 64'd7, 1'b1, 30'd0, 1'b1);
		add_row(pma_pkg::OP_MUL, pma_pkg::MODULUS - 30'd1, pma_pkg::MODULUS - 30'd1, 64'd0,
			1'b1, 30'd1, 1'b1);
		add_row(pma_pkg::OP_MUL, TOP30, pma_pkg::MODULUS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			30'd0, 1'b0);
		add_row(pma_pkg::OP_DIV, 30'd7, 30'd0, 64'd0, 1'b1, 30'd0, 1'b0);
		add_row(pma_pkg::OP_DIV, 30'd6, 30'd3, 64'd0, 1'b1, 30'd2, 1'b0);
		add_row(pma_pkg::OP_DIV, 30'd123456789, 30'd987654321, 64'd0, 1'b0, '0, 1'b0);
		add_row(pma_pkg::OP_NEG, 30'd0, 30'd0, 64'd0, 1'b1, 30'd0, 1'b1);
		add_row(pma_pkg::OP_NEG, 30'd1, 30'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			pma_pkg::MODULUS - 30'd1, 1'b1);
		add_row(pma_pkg::OP_NEG, pma_pkg::MODULUS, pma_pkg::MODULUS - 30'd1, 64'd0, 1'b1,
			30'd0, 1'b0);
		add_row(pma_pkg::OP_POW, 30'd2, 30'd0, 64'd10, 1'b1, 30'd1024, 1'b0);
		add_row(pma_pkg::OP_POW, 30'd0, 30'd0, 64'd5, 1'b1, 30'd0, 1'b1);
		add_row(pma_pkg::OP_POW, 30'd12345, 30'd1, 64'd0, 1'b1, 30'd1, 1'b0);
		add_row(pma_pkg::OP_POW, 30'd12345, 30'd1, 64'h8000_0000_0000_0000, 1'b1, 30'd1, 1'b0);
		add_row(pma_pkg::OP_POW, 30'd3, TOP30, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0, 1'b0);
		add_row(pma_pkg::OP_INV, 30'd0, 30'd0, 64'd0, 1'b1, 30'd0, 1'b1);
		add_row(pma_pkg::OP_INV, 30'd2, 30'd3, 64'd0, 1'b1, 30'd499122177, 1'b0);
		add_row(pma_pkg::OP_INV, pma_pkg::MODULUS - 30'd1, pma_pkg::MODULUS - 30'd1, 64'd0,
			1'b1, pma_pkg::MODULUS - 30'd1, 1'b1);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_requests[i])
			send_word(directed_requests[i], 1'b0);
		wait_for_results();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			send_word(random_request(), (i % 250) < 40);
			if (i == DRAIN_AT)
				wait_for_results();
		end
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("prime_modular_alu_core test passed");
		else
			$display("prime_modular_alu_core test failed");
		$finish;
	end

	initial begin : receiver
		int  run_left;
		bit  holding;
		bit  long_done;
		run_left = 0;
		holding = 1'b0;
		long_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!long_done && words_checked >= 300) begin
				long_done = 1'b1;
				holding = 1'b1;
				run_left = LONG_HOLD;
			end else if (run_left == 0) begin
				holding = !holding;
				if (holding)
					run_left = idle_cycles();
				else
					run_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
				if (run_left == 0) begin
					holding = 1'b0;
					run_left = $urandom_range(1, 12);
				end
			end
			run_left--;
			out_stall <= holding;
		end
	end

	always @(posedge clk) begin : scoreboard
		alu_request_t req;
		alu_result_t  want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				words_checked++;
				if (awaited_results.size() == 0) begin
					note_fault($sformatf("unexpected word: residue %0d equal %0b",
						residue, operands_equal));
				end else begin
					want = awaited_results.pop_front();
					if (residue !== want.residue || operands_equal !== want.equal)
						note_fault($sformatf(
							"word %0d: expected residue %0d equal %0b, got residue %0d equal %0b",
							words_checked, want.residue, want.equal, residue, operands_equal));
				end
			end
			if (in_valid && !in_stall) begin
				if (row_typed) begin
					want.residue = row_residue;
					want.equal = row_equal;
				end else begin
					req.op = pma_pkg::op_t'(opcode);
					req.a = operand_a;
					req.b = operand_b;
					req.w = wide_operand;
					want = predict_word(req);
				end
				awaited_results.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("prime_modular_alu_core test failed");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
src/pma_pkg.sv
src/pma_ctrl.sv
src/pma_dp.sv
src/prime_modular_alu_core.sv
verif/tb.sv
